// ===== hdl/knn_pkg.sv =====
`default_nettype none
package knn_pkg;
  localparam int MAX_FEATURES  = 16;
  localparam int MAX_POINTS    = 1024;
  localparam int MAX_NEIGHBORS = 16;
  localparam int MAX_LABELS    = 16;

  localparam int FEAT_W  = 16;
  localparam int LABEL_W = 4;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 5;
  localparam int DIST_W  = 38;
  localparam int PROD_W  = 33;
  localparam int PIDX_W  = $clog2(MAX_POINTS);
  localparam int FIDX_W  = $clog2(MAX_FEATURES);
  localparam int NIDX_W  = $clog2(MAX_NEIGHBORS);
  localparam int LIDX_W  = $clog2(MAX_LABELS);
  localparam int FADDR_W = PIDX_W + FIDX_W;
  localparam int OUT_TDATA_W = 24;

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_MODE         = 2'd0;
  localparam cfg_idx_t REG_NUM_FEATURES = 2'd1;
  localparam cfg_idx_t REG_NEIGHBORS    = 2'd2;
  localparam cfg_idx_t REG_NUM_LABELS   = 2'd3;

  localparam logic MODE_TRAIN   = 1'b0;
  localparam logic MODE_PREDICT = 1'b1;

  typedef logic [CFG_W-1:0] cfg_val_t;

  function automatic cfg_val_t clamp_cfg(input cfg_val_t v, input cfg_val_t hi);
    cfg_val_t r;
    r = v;
    if (v == '0) r = cfg_val_t'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/knn_ram.sv =====
`default_nettype none
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/knn_classifier_unit.sv =====
`default_nettype none
// k-nearest-neighbor classifier, one vector element per input item: num_features
// signed features, then a label item that yields one result. Train mode copies
// the vector into the point store (all MAX_FEATURES words per label, zero-padded
// past num_features, one feature word a cycle); predict mode scans every stored
// point through one shared subtract-and-square unit (S_RD, S_MUL, S_ACC per
// feature), then scans the k slots for the new worst slot when a point enters
// the neighbor list, then clears the counts, counts votes and picks the label.
// Feature items are only buffered in the idle state. The one shared multiplier
// is used one feature at a time without overlap; no item is taken mid-scan.
// stored_points counts points held; store_full flags a dropped training vector.
module knn_classifier_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] element_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [3:0] predicted_label, [7:4] true_label,
                                       // [18:8] stored_points, [23:19] zero
  output logic             out_tuser,  // store_full
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire knn_pkg::cfg_idx_t cfg_index,
  input  wire knn_pkg::cfg_val_t cfg_data
);
  import knn_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0,  S_WR   = 4'd1,  S_RD   = 4'd2,  S_MUL  = 4'd3,
                         S_ACC  = 4'd4,  S_CMP  = 4'd5,  S_WST0 = 4'd6,  S_WST  = 4'd7,
                         S_VCLR = 4'd8,  S_VOTE = 4'd9,  S_MAX  = 4'd10, S_OUT  = 4'd11;

  logic [3:0]          state_r, state_nxt;
  logic                mode_r;
  cfg_val_t            nf_cfg_r, k_cfg_r, nl_cfg_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                last_pred_r, last_pred_nxt;
  logic [CFG_W-1:0]    eidx_r, eidx_nxt;
  logic [FEAT_W-1:0]   qbuf_r [MAX_FEATURES];
  logic [DIST_W-1:0]   best_d_r [MAX_NEIGHBORS];
  logic [LABEL_W-1:0]  best_l_r [MAX_NEIGHBORS];
  logic [CFG_W-1:0]    vcnt_r [MAX_LABELS];
  logic [CFG_W-1:0]    j_r, j_nxt, x_r, x_nxt;
  logic [COUNT_W-1:0]  p_r, p_nxt;
  logic [DIST_W-1:0]   acc_r, acc_nxt, worst_r, worst_nxt;
  logic [NIDX_W-1:0]   wi_r, wi_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [LABEL_W-1:0]  true_r, true_nxt, pred_r, pred_nxt;
  logic                full_r, full_nxt;
  logic [CFG_W-1:0]    bv_r, bv_nxt;
  logic                out_valid_r;
  logic [23:0]         out_data_r;
  logic                out_full_r;

  cfg_val_t            nf, k, nl;
  logic                in_acc, clear_store, out_free;
  logic [COUNT_W-1:0]  count_eff;

  logic                fw_we, f_re, l_we, l_re;
  logic [FADDR_W-1:0]  f_waddr, f_raddr;
  logic [FEAT_W-1:0]   f_wdata, f_rdata;
  logic [LABEL_W-1:0]  l_rdata;
  logic [PIDX_W-1:0]   l_addr;
  logic signed [FEAT_W:0]     diff;
  logic signed [2*FEAT_W+1:0] sq;

  assign nf = clamp_cfg(nf_cfg_r, cfg_val_t'(MAX_FEATURES));
  assign k  = clamp_cfg(k_cfg_r,  cfg_val_t'(MAX_NEIGHBORS));
  assign nl = clamp_cfg(nl_cfg_r, cfg_val_t'(MAX_LABELS));

  assign cfg_ready   = 1'b1;
  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign clear_store = (mode_r == MODE_TRAIN) && last_pred_r;
  assign count_eff   = clear_store ? '0 : count_r;
  assign out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_full_r;

  // point store: train writes one feature word a cycle, predict reads one per feature in S_RD
  assign fw_we   = (state_r == S_WR);
  assign f_waddr = {count_r[PIDX_W-1:0], j_r[FIDX_W-1:0]};
  assign f_wdata = (j_r < nf) ? qbuf_r[j_r[FIDX_W-1:0]] : '0;
  assign f_re    = (state_r == S_RD);
  assign f_raddr = {p_r[PIDX_W-1:0], j_r[FIDX_W-1:0]};
  assign l_we    = (state_r == S_WR) && (j_r == '0);
  assign l_re    = (state_r == S_RD);
  assign l_addr  = (state_r == S_WR) ? count_r[PIDX_W-1:0] : p_r[PIDX_W-1:0];

  knn_ram #(.WIDTH(FEAT_W), .DEPTH(MAX_POINTS*MAX_FEATURES)) u_feat_ram (
    .clk(clk), .we(fw_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );

  knn_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_POINTS)) u_label_ram (
    .clk(clk), .we(l_we), .waddr(l_addr), .wdata(true_r),
    .re(l_re), .raddr(l_addr), .rdata(l_rdata)
  );

  assign diff = $signed({qbuf_r[j_r[FIDX_W-1:0]][FEAT_W-1], qbuf_r[j_r[FIDX_W-1:0]]})
              - $signed({f_rdata[FEAT_W-1], f_rdata});
  assign sq   = diff * diff;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    last_pred_nxt = last_pred_r;
    eidx_nxt      = eidx_r;
    j_nxt         = j_r;
    x_nxt         = x_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    worst_nxt     = worst_r;
    wi_nxt        = wi_r;
    true_nxt      = true_r;
    pred_nxt      = pred_r;
    full_nxt      = full_r;
    bv_nxt        = bv_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          count_nxt     = count_eff;
          last_pred_nxt = (mode_r == MODE_PREDICT);
          if (eidx_r < nf) begin
            eidx_nxt = eidx_r + 1'b1;
          end else begin
            eidx_nxt = '0;
            true_nxt = in_tdata[LABEL_W-1:0];
            full_nxt = 1'b0;
            pred_nxt = in_tdata[LABEL_W-1:0];
            j_nxt    = '0;
            if (mode_r == MODE_TRAIN) begin
              if (count_eff >= COUNT_W'(MAX_POINTS)) begin
                full_nxt  = 1'b1;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_WR;
              end
            end else begin
              p_nxt     = '0;
              worst_nxt = DIST_INF;
              wi_nxt    = '0;
              state_nxt = (count_r == '0) ? S_VCLR : S_RD;
            end
          end
        end
      end
      S_WR: begin
        j_nxt = j_r + 1'b1;
        if (j_r == CFG_W'(MAX_FEATURES - 1)) begin
          count_nxt = count_r + 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_RD: begin
        if (j_r == '0) acc_nxt = '0;
        state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        acc_nxt = acc_r + DIST_W'(prod_r);
        j_nxt   = j_r + 1'b1;
        state_nxt = (j_r + 1'b1 == nf) ? S_CMP : S_RD;
      end
      S_CMP: begin
        j_nxt = '0;
        if (acc_r < worst_r) begin
          state_nxt = S_WST0;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = (p_r + 1'b1 == count_r) ? S_VCLR : S_RD;
        end
      end
      S_WST0: begin
        worst_nxt = best_d_r[0];
        wi_nxt    = '0;
        x_nxt     = CFG_W'(1);
        state_nxt = S_WST;
      end
      S_WST: begin
        if (x_r < k) begin
          if (best_d_r[x_r[NIDX_W-1:0]] > worst_r) begin
            worst_nxt = best_d_r[x_r[NIDX_W-1:0]];
            wi_nxt    = x_r[NIDX_W-1:0];
          end
          x_nxt = x_r + 1'b1;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = (p_r + 1'b1 == count_r) ? S_VCLR : S_RD;
        end
      end
      S_VCLR: begin
        x_nxt     = '0;
        state_nxt = S_VOTE;
      end
      S_VOTE: begin
        if (x_r < k) begin
          x_nxt = x_r + 1'b1;
        end else begin
          pred_nxt  = '0;
          bv_nxt    = vcnt_r[0];
          x_nxt     = CFG_W'(1);
          state_nxt = S_MAX;
        end
      end
      S_MAX: begin
        if (x_r < nl) begin
          if (vcnt_r[x_r[LIDX_W-1:0]] > bv_r) begin
            bv_nxt   = vcnt_r[x_r[LIDX_W-1:0]];
            pred_nxt = x_r[LABEL_W-1:0];
          end
          x_nxt = x_r + 1'b1;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_TRAIN;
      nf_cfg_r    <= cfg_val_t'(1);
      k_cfg_r     <= cfg_val_t'(1);
      nl_cfg_r    <= cfg_val_t'(1);
      count_r     <= '0;
      last_pred_r <= 1'b1;
      eidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_pred_r <= last_pred_nxt;
      eidx_r      <= eidx_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODE:         mode_r   <= cfg_data[0];
          REG_NUM_FEATURES: nf_cfg_r <= cfg_data;
          REG_NEIGHBORS:    k_cfg_r  <= cfg_data;
          REG_NUM_LABELS:   nl_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready)              out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    x_r     <= x_nxt;
    p_r     <= p_nxt;
    acc_r   <= acc_nxt;
    worst_r <= worst_nxt;
    wi_r    <= wi_nxt;
    true_r  <= true_nxt;
    pred_r  <= pred_nxt;
    full_r  <= full_nxt;
    bv_r    <= bv_nxt;
    if (state_r == S_MUL) prod_r <= sq[PROD_W-1:0];
    if (in_acc && eidx_r < nf) qbuf_r[eidx_r[FIDX_W-1:0]] <= in_tdata;
    if (in_acc && !(eidx_r < nf) && mode_r == MODE_PREDICT) begin
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
        best_d_r[i] <= DIST_INF;
        best_l_r[i] <= '0;
      end
    end
    if (state_r == S_CMP && acc_r < worst_r) begin
      best_d_r[wi_r] <= acc_r;
      best_l_r[wi_r] <= l_rdata;
    end
    if (state_r == S_VCLR) begin
      for (int i = 0; i < MAX_LABELS; i++) vcnt_r[i] <= '0;
    end
    if (state_r == S_VOTE && x_r < k && best_d_r[x_r[NIDX_W-1:0]] != DIST_INF
        && CFG_W'(best_l_r[x_r[NIDX_W-1:0]]) < nl) begin
      vcnt_r[best_l_r[x_r[NIDX_W-1:0]]] <= vcnt_r[best_l_r[x_r[NIDX_W-1:0]]] + 1'b1;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {5'b0, count_r, true_r, pred_r};
      out_full_r <= full_r;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/knn_checker.sv =====
`default_nettype none
module knn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser
);
  import knn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[18:8] == 11'(MAX_POINTS))
    else $error("store_full with store not full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18:8] <= 11'(MAX_POINTS) && out_tdata[23:19] == 5'd0)
    else $error("stored_points out of range");

  a_full_train: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[3:0] == out_tdata[7:4])
    else $error("dropped vector label mismatch");

  // an idle input side with no item offered stays ready
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |=> in_tready)
    else $error("input ready dropped without an item");
endmodule

bind knn_classifier_unit knn_checker u_knn_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire
